>>> sv/mkps_pkg.sv
// Shared types, defaults and ordering function for the Manhattan key point sorter.
package mkps_pkg;

  localparam int MKPS_MAX_POINTS = 32;
  localparam int COORD_W = 32;
  localparam int DIST_W  = 33;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [DIST_W-1:0]  d;
  } point_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

  // True when point a sorts ahead of point b: larger distance, then smaller x, then smaller y.
  function automatic logic goes_before(input point_t a, input point_t b);
    logic result;
    if (a.d != b.d) begin
      result = a.d > b.d;
    end else if (a.x != b.x) begin
      result = a.x < b.x;
    end else begin
      result = a.y < b.y;
    end
    return result;
  endfunction

endpackage

>>> sv/manhattan_key_point_sorter_top.sv
// Top level of the Manhattan key point sorter: input stage, cell chain and drain control.
//
// Input channel (x, y, last_point) and output channel (out_x, out_y, distance,
// end_of_run, overflow) both use valid/stall; a transaction moves when valid
// is high and stall is low.
// Each point's distance is registered in the input stage, then the point is
// inserted into a chain of MAX_POINTS cells, kept sorted by distance (largest
// first), then x ascending, then y ascending. Points stream in at one per cycle
// while in_stall is low. A point arriving when every cell is full is dropped
// and overflow is set on every result of that run.
// After the transaction with last_point, input stalls while the chain drains:
// one result per cycle through cell 0 into the output register while the
// receiver does not stall, the final one marked end_of_run. The first result
// is popped after the last point has passed the input register and the chain.
// When the receiver stalls, the output register and the chain hold.
// Reset empties the chain and clears the internal dropped flag, not the overflow output.
module manhattan_key_point_sorter_top
  import mkps_pkg::*;
#(
  parameter int MAX_POINTS = MKPS_MAX_POINTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  input  logic                      last_point,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic        [DIST_W-1:0]  distance,
  output logic                      end_of_run,
  output logic                      overflow
);

  typedef enum logic {LOAD, DRAIN} state_t;

  state_t     state;
  logic       s1_valid;
  logic       s1_last;
  point_t     s1_pt;
  logic       dropped;
  logic       in_take;
  logic       pop;
  cell_ctrl_t ctrl;

  logic [DIST_W-1:0] mag_x;
  logic [DIST_W-1:0] mag_y;

  point_t cell_pt     [MAX_POINTS];
  logic   cell_valid  [MAX_POINTS];
  logic   cell_before [MAX_POINTS];

  assign in_stall = (state == DRAIN) || (s1_valid && s1_last);
  assign in_take  = in_valid && !in_stall;

  // Sign-extend, then negate when negative; the most negative value fits in 33 bits.
  assign mag_x = x[COORD_W-1] ? (DIST_W'(0) - {x[COORD_W-1], x}) : {1'b0, x};
  assign mag_y = y[COORD_W-1] ? (DIST_W'(0) - {y[COORD_W-1], y}) : {1'b0, y};

  assign pop = (state == DRAIN) && cell_valid[0] && (!out_valid || !out_stall);

  assign ctrl.insert    = (state == LOAD) && s1_valid && !cell_valid[MAX_POINTS-1];
  assign ctrl.shift_out = pop;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    point_t prev_pt;
    logic   prev_valid;
    logic   prev_before;
    point_t next_pt;
    logic   next_valid;

    if (i == 0) begin : g_head
      assign prev_pt     = s1_pt;
      assign prev_valid  = 1'b0;
      assign prev_before = 1'b0;
    end else begin : g_body
      assign prev_pt     = cell_pt[i-1];
      assign prev_valid  = cell_valid[i-1];
      assign prev_before = cell_before[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_tail
      assign next_pt    = s1_pt;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_pt    = cell_pt[i+1];
      assign next_valid = cell_valid[i+1];
    end

    mkps_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_pt      (s1_pt),
      .prev_pt     (prev_pt),
      .prev_valid  (prev_valid),
      .prev_before (prev_before),
      .next_pt     (next_pt),
      .next_valid  (next_valid),
      .pt          (cell_pt[i]),
      .valid       (cell_valid[i]),
      .ahead       (cell_before[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      s1_valid  <= 1'b0;
      s1_last   <= 1'b0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= in_take;
      if (in_take) begin
        s1_last <= last_point;
      end

      unique case (state)
        LOAD: begin
          if (s1_valid) begin
            if (cell_valid[MAX_POINTS-1]) begin
              dropped <= 1'b1;
            end
            if (s1_last) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          // Chain empty: the run is out, start the next set.
          if (!cell_valid[0]) begin
            state   <= LOAD;
            dropped <= 1'b0;
          end
        end
        default: state <= LOAD;
      endcase

      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (pop) begin
        out_x      <= cell_pt[0].x;
        out_y      <= cell_pt[0].y;
        distance   <= cell_pt[0].d;
        end_of_run <= !cell_valid[1];
        overflow   <= dropped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pt.x <= x;
      s1_pt.y <= y;
      s1_pt.d <= mag_x + mag_y;
    end
  end

endmodule

>>> sv/mkps_cell.sv
// One sorting cell: holds a point and shifts it to or from its neighbors.
module mkps_cell
  import mkps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  point_t     new_pt,
  input  point_t     prev_pt,
  input  logic       prev_valid,
  input  logic       prev_before,
  input  point_t     next_pt,
  input  logic       next_valid,
  output point_t     pt,
  output logic       valid,
  output logic       ahead
);

  // An empty cell always yields to the incoming point.
  assign ahead = !valid || goes_before(new_pt, pt);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift_out) begin
      valid <= next_valid;
    end else if (ctrl.insert && ahead) begin
      valid <= prev_before ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_out) begin
      pt <= next_pt;
    end else if (ctrl.insert && ahead) begin
      pt <= prev_before ? prev_pt : new_pt;
    end
  end

endmodule
